/* rtl/lrupr_pkg.sv */
// Shared constants, types and state codes of the LRU page-frame manager.
package lrupr_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;
	localparam int PAGE_W        = 16;
	localparam int SLOT_W        = 4;
	localparam int CNT_W         = 32;
	localparam int CFG_W         = 5;
	localparam int APB_AW        = 3;
	localparam int APB_DW        = 32;

	localparam logic [CFG_W-1:0] FIU_RESET   = 5'd4;
	localparam logic             REG_FRAMES  = 1'b0;
	localparam logic [CNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	// Flags the compare unit hands back after a pass.
	typedef struct packed {
		logic found;
		logic empty_found;
	} scan_flags_t;

	// Write strobes towards the frame store.
	typedef struct packed {
		logic stamp_we;
		logic page_we;
	} wr_ctl_t;

endpackage

/* rtl/lrupr_frames.sv */
// Frame store: page and stamp memories, valid bits, registered read port.
module lrupr_frames #(
	parameter int MAX_FRAMES = lrupr_pkg::FRAMES_DEF,
	parameter int PW         = lrupr_pkg::PAGE_W,
	parameter int FW         = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [FW-1:0]               rd_idx,
	output logic                        rd_valid,
	output logic [PW-1:0]               rd_page,
	output logic [lrupr_pkg::CNT_W-1:0] rd_stamp,
	input  lrupr_pkg::wr_ctl_t          wr_ctl,
	input  logic [FW-1:0]               wr_idx,
	input  logic [PW-1:0]               wr_page,
	input  logic [lrupr_pkg::CNT_W-1:0] wr_stamp
);

	logic [PW-1:0]               page_mem  [MAX_FRAMES];
	logic [lrupr_pkg::CNT_W-1:0] stamp_mem [MAX_FRAMES];
	logic [MAX_FRAMES-1:0]       valid_q;
	logic                        rd_valid_q;
	logic [PW-1:0]               rd_page_q;
	logic [lrupr_pkg::CNT_W-1:0] rd_stamp_q;

	always_ff @(posedge clk) begin
		if (wr_ctl.page_we) begin
			page_mem[wr_idx] <= wr_page;
		end
		if (wr_ctl.stamp_we) begin
			stamp_mem[wr_idx] <= wr_stamp;
		end
	end

	always_ff @(posedge clk) begin
		rd_page_q  <= page_mem[rd_idx];
		rd_stamp_q <= stamp_mem[rd_idx];
		rd_valid_q <= valid_q[rd_idx];
	end

	// Mark a frame occupied when a fault fills it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ctl.page_we) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	assign rd_valid = rd_valid_q;
	assign rd_page  = rd_page_q;
	assign rd_stamp = rd_stamp_q;

endmodule

/* rtl/lrupr_scan.sv */
// Shared compare unit: one frame per cycle for hit, first empty and oldest stamp.
module lrupr_scan #(
	parameter int PW = lrupr_pkg::PAGE_W,
	parameter int FW = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        en,
	input  logic [FW-1:0]               idx,
	input  logic                        fr_valid,
	input  logic [PW-1:0]               fr_page,
	input  logic [lrupr_pkg::CNT_W-1:0] fr_stamp,
	input  logic [PW-1:0]               target,
	output lrupr_pkg::scan_flags_t      flags,
	output logic [FW-1:0]               hit_idx,
	output logic [FW-1:0]               empty_idx,
	output logic [FW-1:0]               old_idx,
	output logic [PW-1:0]               old_page
);

	logic                        found_q;
	logic                        empty_q;
	logic                        old_any_q;
	logic [FW-1:0]               hit_idx_q;
	logic [FW-1:0]               empty_idx_q;
	logic [FW-1:0]               old_idx_q;
	logic [PW-1:0]               old_page_q;
	logic [lrupr_pkg::CNT_W-1:0] old_stamp_q;
	logic                        take_hit;
	logic                        take_empty;
	logic                        take_old;

	assign take_hit   = en && fr_valid && !found_q && (fr_page == target);
	assign take_empty = en && !fr_valid && !empty_q;
	// Strict less-than keeps the lowest index on equal stamps.
	assign take_old   = en && fr_valid && (!old_any_q || (fr_stamp < old_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			empty_q   <= 1'b0;
			old_any_q <= 1'b0;
		end else if (clear) begin
			found_q   <= 1'b0;
			empty_q   <= 1'b0;
			old_any_q <= 1'b0;
		end else begin
			if (take_hit) begin
				found_q <= 1'b1;
			end
			if (take_empty) begin
				empty_q <= 1'b1;
			end
			if (take_old) begin
				old_any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q <= idx;
		end
		if (take_empty) begin
			empty_idx_q <= idx;
		end
		if (take_old) begin
			old_idx_q   <= idx;
			old_page_q  <= fr_page;
			old_stamp_q <= fr_stamp;
		end
	end

	assign flags.found       = found_q;
	assign flags.empty_found = empty_q;
	assign hit_idx           = hit_idx_q;
	assign empty_idx         = empty_idx_q;
	assign old_idx           = old_idx_q;
	assign old_page          = old_page_q;

endmodule

/* rtl/lru_page_replacement.sv */
// Fully associative LRU page-frame manager: APB register, sequencer, counters, result beat.
// The result beat follows the scan of the n active frames (1..MAX_FRAMES) by the single
// compare unit, which walks the frame store one entry per cycle through its registered
// read port, and then the drain and done states.
// busy stays high through scan, drain and done, and start is taken again in the done
// cycle, so each reference waits for the last; the receiver cannot stall the beat.
// Reset clears valid bits, reference clock, hit and fault totals and sets frames_in_use to 4.
module lru_page_replacement #(
	parameter int MAX_FRAMES = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lrupr_pkg::APB_AW-1:0]  paddr,
	input  logic [lrupr_pkg::APB_DW-1:0]  pwdata,
	output logic [lrupr_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	// command side
	input  logic                          start,
	output logic                          busy,
	input  logic [lrupr_pkg::PAGE_W-1:0]  page,
	// result side
	output logic                          done,
	output logic                          hit,
	output logic [lrupr_pkg::SLOT_W-1:0]  slot,
	output logic                          evicted_valid,
	output logic [lrupr_pkg::PAGE_W-1:0]  evicted_page,
	output logic [lrupr_pkg::CNT_W-1:0]   hit_total,
	output logic [lrupr_pkg::CNT_W-1:0]   fault_total
);

	// Stored page width: the page port carries 16 bits, PAGE_BITS may narrow it.
	localparam int PW = (PAGE_BITS < lrupr_pkg::PAGE_W) ? PAGE_BITS : lrupr_pkg::PAGE_W;
	localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = $clog2(MAX_FRAMES + 1);

	lrupr_pkg::state_t            state_q;
	logic [lrupr_pkg::CFG_W-1:0]  fiu_q;
	logic [PW-1:0]                page_q;
	logic [CW-1:0]                cnt_q;
	logic [FW-1:0]                rd_idx_q;
	logic                         cmp_en_s1;
	logic [FW-1:0]                cmp_idx_s1;
	logic [lrupr_pkg::CNT_W-1:0]  ref_clk_q;
	logic [lrupr_pkg::CNT_W-1:0]  hit_cnt_q;
	logic [lrupr_pkg::CNT_W-1:0]  fault_cnt_q;
	logic                         done_q;
	logic                         hit_q;
	logic [lrupr_pkg::SLOT_W-1:0] slot_q;
	logic                         evv_q;
	logic [lrupr_pkg::PAGE_W-1:0] evp_q;

	logic                         cfg_wr;
	logic                         accept;
	logic                         last_rd;
	logic [CW-1:0]                act_cnt;
	logic                         fr_valid;
	logic [PW-1:0]                fr_page;
	logic [lrupr_pkg::CNT_W-1:0]  fr_stamp;
	lrupr_pkg::scan_flags_t       flags;
	logic [FW-1:0]                hit_idx;
	logic [FW-1:0]                empty_idx;
	logic [FW-1:0]                old_idx;
	logic [PW-1:0]                old_page;
	logic [FW-1:0]                pick_idx;
	logic                         evict;
	lrupr_pkg::wr_ctl_t           wr_ctl;

	// ---------------- configuration register ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= lrupr_pkg::FIU_RESET;
		end else if (cfg_wr && (paddr[2] == lrupr_pkg::REG_FRAMES)) begin
			fiu_q <= pwdata[lrupr_pkg::CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == lrupr_pkg::REG_FRAMES) begin
			prdata = lrupr_pkg::APB_DW'(fiu_q);
		end
	end

	// Clamp the frame count: zero acts as one, anything past the store as its depth.
	always_comb begin
		priority if (fiu_q == '0) begin
			act_cnt = CW'(1);
		end else if (32'(fiu_q) > MAX_FRAMES) begin
			act_cnt = CW'(MAX_FRAMES);
		end else begin
			act_cnt = CW'(fiu_q);
		end
	end

	// ---------------- sequencer ----------------
	assign busy    = (state_q != lrupr_pkg::S_IDLE);
	assign accept  = start && !busy;
	assign last_rd = ((CW'(rd_idx_q) + CW'(1)) == cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lrupr_pkg::S_IDLE;
			cmp_en_s1 <= 1'b0;
			rd_idx_q  <= '0;
		end else begin
			// Compare stage sees the frame read in the previous scan cycle.
			cmp_en_s1 <= (state_q == lrupr_pkg::S_SCAN);
			unique case (state_q)
				lrupr_pkg::S_IDLE: begin
					if (start) begin
						rd_idx_q <= '0;
						state_q  <= lrupr_pkg::S_SCAN;
					end
				end
				lrupr_pkg::S_SCAN: begin
					if (last_rd) begin
						state_q <= lrupr_pkg::S_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + FW'(1);
					end
				end
				lrupr_pkg::S_DRAIN: begin
					state_q <= lrupr_pkg::S_DONE;
				end
				lrupr_pkg::S_DONE: begin
					state_q <= lrupr_pkg::S_IDLE;
				end
				default: begin
					state_q <= lrupr_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Latch the reference and the frame count for the whole pass.
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q;
		if (accept) begin
			page_q <= page[PW-1:0];
			cnt_q  <= act_cnt;
		end
	end

	// ---------------- frame store and compare unit ----------------
	lrupr_frames #(
		.MAX_FRAMES (MAX_FRAMES),
		.PW         (PW),
		.FW         (FW)
	) u_frames (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx_q),
		.rd_valid (fr_valid),
		.rd_page  (fr_page),
		.rd_stamp (fr_stamp),
		.wr_ctl   (wr_ctl),
		.wr_idx   (pick_idx),
		.wr_page  (page_q),
		.wr_stamp (ref_clk_q)
	);

	lrupr_scan #(
		.PW (PW),
		.FW (FW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.en        (cmp_en_s1),
		.idx       (cmp_idx_s1),
		.fr_valid  (fr_valid),
		.fr_page   (fr_page),
		.fr_stamp  (fr_stamp),
		.target    (page_q),
		.flags     (flags),
		.hit_idx   (hit_idx),
		.empty_idx (empty_idx),
		.old_idx   (old_idx),
		.old_page  (old_page)
	);

	// ---------------- decision and update ----------------
	always_comb begin
		evict = 1'b0;
		priority if (flags.found) begin
			pick_idx = hit_idx;
		end else if (flags.empty_found) begin
			pick_idx = empty_idx;
		end else begin
			pick_idx = old_idx;
			evict    = 1'b1;
		end
	end

	// Stamp the chosen frame on every reference; fill page and valid only on a fault.
	assign wr_ctl.stamp_we = (state_q == lrupr_pkg::S_DONE);
	assign wr_ctl.page_we  = (state_q == lrupr_pkg::S_DONE) && !flags.found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clk_q   <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (state_q == lrupr_pkg::S_DONE);
			if (state_q == lrupr_pkg::S_DONE) begin
				ref_clk_q <= ref_clk_q + lrupr_pkg::CNT_W'(1);
				if (flags.found) begin
					if (hit_cnt_q != lrupr_pkg::COUNT_MAX) begin
						hit_cnt_q <= hit_cnt_q + lrupr_pkg::CNT_W'(1);
					end
				end else if (fault_cnt_q != lrupr_pkg::COUNT_MAX) begin
					fault_cnt_q <= fault_cnt_q + lrupr_pkg::CNT_W'(1);
				end
			end
		end
	end

	// Result beat registers; hold between beats.
	always_ff @(posedge clk) begin
		if (state_q == lrupr_pkg::S_DONE) begin
			hit_q  <= flags.found;
			slot_q <= lrupr_pkg::SLOT_W'(pick_idx);
			evv_q  <= evict;
			evp_q  <= evict ? lrupr_pkg::PAGE_W'(old_page) : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign evicted_valid = evv_q;
	assign evicted_page  = evp_q;
	assign hit_total     = hit_cnt_q;
	assign fault_total   = fault_cnt_q;

endmodule

/* rtl/lrupr_checker.sv */
// Port-level checks of the LRU page-frame manager and their binding.
module lrupr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          hit,
	input logic                          evicted_valid,
	input logic [lrupr_pkg::PAGE_W-1:0]  evicted_page,
	input logic [lrupr_pkg::CNT_W-1:0]   hit_total,
	input logic [lrupr_pkg::CNT_W-1:0]   fault_total
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted start");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat lasted more than one cycle");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !evicted_valid && (hit_total != '0))
		else $error("hit beat reports an eviction or a zero hit total");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> (fault_total != '0))
		else $error("fault beat with zero fault total");

	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !evicted_valid |-> (evicted_page == '0))
		else $error("evicted page not zero without eviction");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.evicted_valid (evicted_valid),
	.evicted_page  (evicted_page),
	.hit_total     (hit_total),
	.fault_total   (fault_total)
);

/* tb/tb_lru_page_replacement.sv */
// Self-checking testbench for the LRU page-frame manager: directed cases, then random traffic.
module tb_lru_page_replacement;

	// Byte addresses on the configuration port: the frame count register, and the
	// next word up, which maps to no register and must swallow writes.
	localparam logic [lrupr_pkg::APB_AW-1:0] ADDR_FRAMES =
		lrupr_pkg::APB_AW'(4 * int'(lrupr_pkg::REG_FRAMES));
	localparam logic [lrupr_pkg::APB_AW-1:0] ADDR_SPARE  =
		lrupr_pkg::APB_AW'(4 * (int'(lrupr_pkg::REG_FRAMES) + 1));
	localparam int NUM_FRAMES = lrupr_pkg::FRAMES_DEF;
	localparam int POOL_DEPTH = 24;
	// Longest reference (16 frames) plus margin, for the quiet spell at the end.
	localparam int SETTLE_CYCLES = 32;

	typedef struct {
		logic                           hit;
		logic [lrupr_pkg::SLOT_W-1:0]   slot;
		logic                           evicted_valid;
		logic [lrupr_pkg::PAGE_W-1:0]   evicted_page;
		logic [lrupr_pkg::CNT_W-1:0]    hit_total;
		logic [lrupr_pkg::CNT_W-1:0]    fault_total;
	} lookup_outcome_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [lrupr_pkg::APB_AW-1:0]   paddr;
	logic [lrupr_pkg::APB_DW-1:0]   pwdata;
	logic [lrupr_pkg::APB_DW-1:0]   prdata;
	logic                           pready;
	logic                           start;
	logic                           busy;
	logic [lrupr_pkg::PAGE_W-1:0]   page;
	logic                           done;
	logic                           hit;
	logic [lrupr_pkg::SLOT_W-1:0]   slot;
	logic                           evicted_valid;
	logic [lrupr_pkg::PAGE_W-1:0]   evicted_page;
	logic [lrupr_pkg::CNT_W-1:0]    hit_total;
	logic [lrupr_pkg::CNT_W-1:0]    fault_total;

	// Shadow of the frame store, the reference clock, both totals and the register.
	logic [lrupr_pkg::PAGE_W-1:0]   shadow_page [NUM_FRAMES];
	logic                           shadow_valid [NUM_FRAMES];
	logic [lrupr_pkg::CNT_W-1:0]    shadow_stamp [NUM_FRAMES];
	logic [lrupr_pkg::CNT_W-1:0]    shadow_clock;
	logic [lrupr_pkg::CNT_W-1:0]    shadow_hits;
	logic [lrupr_pkg::CNT_W-1:0]    shadow_faults;
	logic [lrupr_pkg::CFG_W-1:0]    shadow_frames;

	// Outcomes of accepted references, oldest first, waiting for their result beat.
	lookup_outcome_t     pending_outcomes [$];
	int                  mismatch_count;
	int                  sender_idle_pct;

	lru_page_replacement DUT (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [lrupr_pkg::CNT_W-1:0] got,
			input logic [lrupr_pkg::CNT_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
		end
	endtask

	// Work out the outcome of one reference and advance the shadow state, in the
	// same single pass the block makes: first matching frame, first empty frame
	// and oldest stamp (lowest index on ties) among the active frames only.
	function automatic lookup_outcome_t predict_lookup(input logic [lrupr_pkg::PAGE_W-1:0] pg);
		lookup_outcome_t r;
		int active, hit_at, empty_at, oldest_at, frame;
		logic found, have_empty;
		logic [lrupr_pkg::CNT_W-1:0] oldest;
		r = '{default: '0};
		// A count of zero behaves as one; anything past the store behaves as full.
		if (shadow_frames == 0)
			active = 1;
		else if (int'(shadow_frames) > NUM_FRAMES)
			active = NUM_FRAMES;
		else
			active = int'(shadow_frames);
		found = 1'b0;
		have_empty = 1'b0;
		hit_at = 0;
		empty_at = 0;
		oldest_at = 0;
		oldest = '0;
		for (int j = 0; j < active; j++) begin
			if (shadow_valid[j]) begin
				if (!found && shadow_page[j] == pg) begin
					found = 1'b1;
					hit_at = j;
				end
				if (j == 0 || shadow_stamp[j] < oldest) begin
					oldest = shadow_stamp[j];
					oldest_at = j;
				end
			end else if (!have_empty) begin
				have_empty = 1'b1;
				empty_at = j;
			end
		end
		if (found) begin
			frame = hit_at;
			r.hit = 1'b1;
			if (shadow_hits != lrupr_pkg::COUNT_MAX)
				shadow_hits++;
		end else begin
			frame = have_empty ? empty_at : oldest_at;
			if (!have_empty) begin
				r.evicted_valid = 1'b1;
				r.evicted_page = shadow_page[frame];
			end
			shadow_page[frame] = pg;
			shadow_valid[frame] = 1'b1;
			if (shadow_faults != lrupr_pkg::COUNT_MAX)
				shadow_faults++;
		end
		shadow_stamp[frame] = shadow_clock;
		shadow_clock++;
		r.slot = lrupr_pkg::SLOT_W'(frame);
		r.hit_total = shadow_hits;
		r.fault_total = shadow_faults;
		return r;
	endfunction

	// Offer one page reference. Each falling edge either idles the sender (start low,
	// page scrambled as noise) or presents the page; the beat is taken at the first
	// rising edge that sees start high and busy low. Start is left high on return so
	// that back-to-back references keep it up.
	task automatic send_reference(input logic [lrupr_pkg::PAGE_W-1:0] pg);
		logic taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if ($urandom_range(0, 99) < sender_idle_pct) begin
				start <= 1'b0;
				page <= lrupr_pkg::PAGE_W'($urandom());
			end else begin
				start <= 1'b1;
				page <= pg;
				@(posedge clk);
				taken = (busy === 1'b0);
			end
		end
		pending_outcomes.push_back(predict_lookup(pg));
	endtask

	task automatic release_start();
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Hold until every outstanding result beat has come back and the block is free.
	task automatic wait_drained();
		while (pending_outcomes.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [lrupr_pkg::APB_AW-1:0] addr,
			input logic [lrupr_pkg::APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		// Only register index zero exists; other word addresses drop the write.
		if (addr[lrupr_pkg::APB_AW-1:2] == lrupr_pkg::REG_FRAMES)
			shadow_frames = data[lrupr_pkg::CFG_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_frame_count();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_FRAMES;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		check_field("frames_in_use readback", prdata, lrupr_pkg::CNT_W'(shadow_frames));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Change the frame count with the block idle; upper data bits carry noise.
	task automatic set_frame_count(input logic [lrupr_pkg::CFG_W-1:0] count);
		logic [lrupr_pkg::APB_DW-1:0] data;
		data = $urandom();
		data[lrupr_pkg::CFG_W-1:0] = count;
		release_start();
		wait_drained();
		apb_write(ADDR_FRAMES, data);
		read_frame_count();
	endtask

	// Every result beat is compared with the oldest outstanding outcome.
	always @(posedge clk) begin
		lookup_outcome_t want;
		if (done === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result beat with no reference outstanding");
			end else begin
				want = pending_outcomes.pop_front();
				check_field("hit", hit, want.hit);
				check_field("slot", slot, want.slot);
				check_field("evicted_valid", evicted_valid, want.evicted_valid);
				check_field("evicted_page", evicted_page, want.evicted_page);
				check_field("hit_total", hit_total, want.hit_total);
				check_field("fault_total", fault_total, want.fault_total);
			end
		end
	end

	// Reset value of the register, filling the four default frames with extreme
	// pages, hits, and replacement of the least recently used frame twice.
	task automatic test_reset_and_fill();
		read_frame_count();
		send_reference(16'h0000);
		send_reference(16'hFFFF);
		send_reference(16'h5555);
		send_reference(16'hAAAA);
		send_reference(16'h0000);
		send_reference(16'h1234);
		send_reference(16'h5555);
		send_reference(16'hFFFF);
	endtask

	// A write to an unmapped word must leave the register alone; only the low
	// five data bits of a real write count.
	task automatic test_register_index();
		release_start();
		wait_drained();
		apb_write(ADDR_SPARE, 32'h0000_0001);
		read_frame_count();
		apb_write(ADDR_FRAMES, 32'hFFFF_FFE1);
		read_frame_count();
		send_reference(16'h1234);
		send_reference(16'h0000);
		send_reference(16'h0000);
	endtask

	// Zero acts as a single frame; counts above the store size act as the full store.
	task automatic test_frame_count_limits();
		set_frame_count(5'd0);
		send_reference(16'h00FF);
		send_reference(16'h00FF);
		set_frame_count(5'd31);
		send_reference(16'hFFFF);
		send_reference(16'h8001);
		set_frame_count(5'd17);
		send_reference(16'h7FFE);
		set_frame_count(5'd16);
	endtask

	// Shrink to one frame so a page still resident higher up lands again in frame
	// zero, then grow back: the duplicate must hit in the lowest frame.
	task automatic test_shrink_and_grow();
		set_frame_count(5'd1);
		send_reference(16'h5555);
		set_frame_count(5'd16);
		send_reference(16'h5555);
	endtask

	// Batches of references under a fresh frame count each. Most pages come from a
	// small pool so that hits and evictions are common; a share walk the pool in
	// order to thrash the LRU order, the rest are arbitrary pages. The pool is kept
	// across some batches so that frames left behind by a shrink meet their pages again.
	task automatic test_random_traffic(input int items, input int idle_pct);
		logic [lrupr_pkg::PAGE_W-1:0] pool [POOL_DEPTH];
		int pool_size, batch, left, pick;
		logic [lrupr_pkg::CFG_W-1:0] count;
		logic [lrupr_pkg::PAGE_W-1:0] pg;
		sender_idle_pct = idle_pct;
		pool_size = 8;
		foreach (pool[k])
			pool[k] = lrupr_pkg::PAGE_W'($urandom());
		left = items;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0: count = 5'd0;
				1: count = 5'd31;
				2: count = 5'd16;
				3: count = 5'd1;
				4: count = lrupr_pkg::CFG_W'($urandom_range(17, 30));
				default: count = lrupr_pkg::CFG_W'($urandom_range(2, 15));
			endcase
			set_frame_count(count);
			if ($urandom_range(0, 1) == 1) begin
				pool_size = $urandom_range(2, POOL_DEPTH);
				foreach (pool[k])
					pool[k] = lrupr_pkg::PAGE_W'($urandom());
			end
			batch = $urandom_range(30, 70);
			if (batch > left)
				batch = left;
			for (int i = 0; i < batch; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					pg = pool[$urandom_range(0, pool_size - 1)];
				else if (pick < 85)
					pg = pool[i % pool_size];
				else
					pg = lrupr_pkg::PAGE_W'($urandom());
				send_reference(pg);
			end
			left -= batch;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		page = '0;
		mismatch_count = 0;
		sender_idle_pct = 0;
		// Shadow state as it stands after reset.
		for (int j = 0; j < NUM_FRAMES; j++) begin
			shadow_page[j] = '0;
			shadow_valid[j] = 1'b0;
			shadow_stamp[j] = '0;
		end
		shadow_clock = '0;
		shadow_hits = '0;
		shadow_faults = '0;
		shadow_frames = lrupr_pkg::FIU_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_and_fill();
		test_register_index();
		test_frame_count_limits();
		test_shrink_and_grow();
		// Sender idles rarely, often, then never.
		test_random_traffic(544, 9);
		test_random_traffic(544, 65);
		test_random_traffic(544, 0);

		// Drain, then keep watching for stray result beats.
		release_start();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#3_200_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* lru_page_replacement.f */
rtl/lrupr_pkg.sv
rtl/lrupr_frames.sv
rtl/lrupr_scan.sv
rtl/lru_page_replacement.sv
rtl/lrupr_checker.sv
tb/tb_lru_page_replacement.sv
